// File: hdl/cian_pkg.sv
// Shared constants, types and helpers for the checked integer ALU.
package cian_pkg;

  localparam int FieldW = 64;
  localparam int DataW  = 64;
  localparam int ProdW  = 2 * FieldW;

  localparam logic [3:0] KIND_ADD   = 4'd0;
  localparam logic [3:0] KIND_SUB   = 4'd1;
  localparam logic [3:0] KIND_MUL   = 4'd2;
  localparam logic [3:0] KIND_DIV   = 4'd3;
  localparam logic [3:0] KIND_NEG   = 4'd4;
  localparam logic [3:0] KIND_NOT   = 4'd5;
  localparam logic [3:0] KIND_EQ    = 4'd6;
  localparam logic [3:0] KIND_NE    = 4'd7;
  localparam logic [3:0] KIND_LT    = 4'd8;
  localparam logic [3:0] KIND_LE    = 4'd9;
  localparam logic [3:0] KIND_GT    = 4'd10;
  localparam logic [3:0] KIND_GE    = 4'd11;
  localparam logic [3:0] KIND_LOGIC = 4'd12;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [1:0] {
    OP_DONE,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              neg;
    logic [FieldW-1:0] val;
    logic              is_null;
    logic [1:0]        st;
  } ctl_t;

  function automatic logic [FieldW-1:0] sext(input logic [DataW-1:0] x);
    logic signed [DataW-1:0] s;
    s = $signed(x);
    return FieldW'(s);
  endfunction

endpackage

// File: hdl/checked_int_alu_with_nulls_core.sv
// Top level: pipelined overflow-checked integer ALU with SQL NULL handling.
//
//  channel | signals                                              | dir
//  in      | in_valid, in_stall, kind, operand_a, operand_b,      | in
//          | a_is_null, b_is_null, use_or                         |
//  out     | out_valid, out_stall, result_value, result_is_null,  | out
//          | status                                               |
//
// One word per cycle while the output is not stalled; a word is registered into
// stage 0, passes stages 1 .. DW, where the restoring divider takes one quotient
// bit per stage, and then the output register. Multiply uses four 32x32 partial
// products over three stages in parallel with the divider.
// All stages move together; a stalled output freezes the whole pipe and
// stalls the input. Synchronous reset clears only the valid bits.
module checked_int_alu_with_nulls_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  kind,
  input  logic [cian_pkg::FieldW-1:0] operand_a,
  input  logic [cian_pkg::FieldW-1:0] operand_b,
  input  logic                        a_is_null,
  input  logic                        b_is_null,
  input  logic                        use_or,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cian_pkg::FieldW-1:0] result_value,
  output logic                        result_is_null,
  output logic [1:0]                  status
);

  localparam int DW = cian_pkg::DataW;
  localparam int FW = cian_pkg::FieldW;
  localparam int PW = cian_pkg::ProdW;
  localparam int HW = FW / 2;
  localparam int MulEnd = 4;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---- decode and simple ops ----
  logic [DW-1:0] a, b, ma, mb, a_neg;
  logic [DW:0]   sum, dif;
  logic          a_true, b_true, a_false, b_false, slt, eq, a_min;
  cian_pkg::ctl_t c0;

  always_comb begin
    a      = operand_a[DW-1:0];
    b      = operand_b[DW-1:0];
    a_neg  = -a;
    ma     = a[DW-1] ? a_neg : a;
    mb     = b[DW-1] ? -b : b;
    sum    = {a[DW-1], a} + {b[DW-1], b};
    dif    = {a[DW-1], a} - {b[DW-1], b};
    eq     = (a == b);
    slt    = ($signed(a) < $signed(b));
    a_min  = (a == {1'b1, {(DW-1){1'b0}}});
    a_true  = !a_is_null && (a != '0);
    a_false = !a_is_null && (a == '0);
    b_true  = !b_is_null && (b != '0);
    b_false = !b_is_null && (b == '0);
    c0 = '{op: cian_pkg::OP_DONE, neg: a[DW-1] ^ b[DW-1], val: '0,
           is_null: 1'b0, st: cian_pkg::ST_OK};
    unique case (kind)
      cian_pkg::KIND_LOGIC: begin
        if (!use_or) begin
          if (a_false || b_false) c0.val = '0;
          else if (a_is_null || b_is_null) c0.is_null = 1'b1;
          else c0.val = FW'(1);
        end else begin
          if (a_true || b_true) c0.val = FW'(1);
          else if (a_is_null || b_is_null) c0.is_null = 1'b1;
          else c0.val = '0;
        end
      end
      cian_pkg::KIND_NEG, cian_pkg::KIND_NOT: begin
        if (a_is_null) c0.is_null = 1'b1;
        else if (kind == cian_pkg::KIND_NOT) c0.val = FW'(a == '0);
        else if (a_min) c0.st = cian_pkg::ST_OVF;
        else c0.val = cian_pkg::sext(a_neg);
      end
      cian_pkg::KIND_ADD, cian_pkg::KIND_SUB, cian_pkg::KIND_MUL, cian_pkg::KIND_DIV,
      cian_pkg::KIND_EQ, cian_pkg::KIND_NE, cian_pkg::KIND_LT, cian_pkg::KIND_LE,
      cian_pkg::KIND_GT, cian_pkg::KIND_GE: begin
        if (a_is_null || b_is_null) begin
          c0.is_null = 1'b1;
        end else begin
          unique case (kind)
            cian_pkg::KIND_EQ: c0.val = FW'(eq);
            cian_pkg::KIND_NE: c0.val = FW'(!eq);
            cian_pkg::KIND_LT: c0.val = FW'(slt);
            cian_pkg::KIND_LE: c0.val = FW'(slt || eq);
            cian_pkg::KIND_GT: c0.val = FW'(!slt && !eq);
            cian_pkg::KIND_GE: c0.val = FW'(!slt);
            cian_pkg::KIND_ADD: begin
              if (sum[DW] != sum[DW-1]) c0.st = cian_pkg::ST_OVF;
              else c0.val = cian_pkg::sext(sum[DW-1:0]);
            end
            cian_pkg::KIND_SUB: begin
              if (dif[DW] != dif[DW-1]) c0.st = cian_pkg::ST_OVF;
              else c0.val = cian_pkg::sext(dif[DW-1:0]);
            end
            cian_pkg::KIND_MUL: c0.op = cian_pkg::OP_MUL;
            default: begin
              if (b == '0) c0.st = cian_pkg::ST_DIV0;
              else if (a_min && (b == '1)) c0.st = cian_pkg::ST_OVF;
              else c0.op = cian_pkg::OP_DIV;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // ---- pipeline stages: 0 .. DW carry control and divider state ----
  logic             vld [0:DW];
  cian_pkg::ctl_t   ctl [0:DW];
  logic [DW-1:0]    rem [0:DW];
  logic [DW-1:0]    quo [0:DW];
  logic [DW-1:0]    den [0:DW];

  // multiplier side lane, aligned to stages 1..3
  logic [FW-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [FW:0]   mid;
  logic [FW-1:0] s2_ll, s2_hh;
  logic [PW-1:0] prod;

  logic [FW-1:0] ua, ub;
  assign ua = FW'(quo[0]);
  assign ub = FW'(den[0]);

  // restoring divide step per stage
  logic [DW:0]   trial [0:DW-1];
  logic [DW:0]   diffd [0:DW-1];
  always_comb begin
    for (int k = 0; k < DW; k++) begin
      trial[k] = {rem[k], quo[k][DW-1]};
      diffd[k] = trial[k] - {1'b0, den[k]};
    end
  end

  // multiply result merged into control entering stage MulEnd
  cian_pkg::ctl_t mul_ctl;
  logic [PW-1:0]  limit;
  logic [DW-1:0]  plo;
  always_comb begin
    mul_ctl = ctl[MulEnd-1];
    limit   = ctl[MulEnd-1].neg ? (PW'(1) << (DW-1)) : ((PW'(1) << (DW-1)) - PW'(1));
    plo     = ctl[MulEnd-1].neg ? -prod[DW-1:0] : prod[DW-1:0];
    if (ctl[MulEnd-1].op == cian_pkg::OP_MUL) begin
      mul_ctl.op = cian_pkg::OP_DONE;
      if (prod > limit) begin
        mul_ctl.st  = cian_pkg::ST_OVF;
        mul_ctl.val = '0;
      end else begin
        mul_ctl.val = cian_pkg::sext(plo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DW; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= DW; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= c0;
      rem[0] <= '0;
      quo[0] <= ma;
      den[0] <= mb;
      for (int k = 0; k < DW; k++) begin
        if (k + 1 == MulEnd) ctl[k+1] <= mul_ctl;
        else ctl[k+1] <= ctl[k];
        den[k+1] <= den[k];
        if (!diffd[k][DW]) begin
          rem[k+1] <= diffd[k][DW-1:0];
          quo[k+1] <= {quo[k][DW-2:0], 1'b1};
        end else begin
          rem[k+1] <= trial[k][DW-1:0];
          quo[k+1] <= {quo[k][DW-2:0], 1'b0};
        end
      end
      pp_ll <= FW'(ua[HW-1:0] * ub[HW-1:0]);
      pp_lh <= FW'(ua[HW-1:0] * ub[FW-1:HW]);
      pp_hl <= FW'(ua[FW-1:HW] * ub[HW-1:0]);
      pp_hh <= FW'(ua[FW-1:HW] * ub[FW-1:HW]);
      mid   <= {1'b0, pp_lh} + {1'b0, pp_hl};
      s2_ll <= pp_ll;
      s2_hh <= pp_hh;
      prod  <= {s2_hh, s2_ll} + (PW'(mid) << HW);
    end
  end

  // ---- output register ----
  logic [DW-1:0] qs;
  assign qs = ctl[DW].neg ? -quo[DW] : quo[DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_is_null <= ctl[DW].is_null;
      status         <= ctl[DW].st;
      if (ctl[DW].op == cian_pkg::OP_DIV) result_value <= cian_pkg::sext(qs);
      else result_value <= ctl[DW].val;
    end
  end

endmodule

// File: hdl/cian_checker.sv
// Port-level checks for the checked integer ALU, bound to the top level.
module cian_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [cian_pkg::FieldW-1:0] result_value,
  input logic                        result_is_null,
  input logic [1:0]                  status
);

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cian_pkg::ST_OK |-> result_value == '0 && !result_is_null)
    else $error("error word carries value or null");

  a_null_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_is_null |-> result_value == '0 && status == cian_pkg::ST_OK)
    else $error("null word carries value or status");

  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("stalled output word changed");

endmodule

bind checked_int_alu_with_nulls_core cian_checker u_cian_checker (.*);

// File: test/checked_int_alu_with_nulls_core_tb.sv
// Testbench for the checked integer ALU: directed and random words, scoreboard check.
`timescale 1ns / 1ps

module checked_int_alu_with_nulls_core_tb;

  localparam int Latency = cian_pkg::DataW + 1;
  localparam longint unsigned CycleLimit = 400000;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinusOne = '1;

  typedef struct packed {
    logic [63:0] value;
    logic        is_null;
    logic [1:0]  st;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] kind = cian_pkg::KIND_ADD;
  logic [cian_pkg::FieldW-1:0] operand_a = '0;
  logic [cian_pkg::FieldW-1:0] operand_b = '0;
  logic a_is_null = 1'b0;
  logic b_is_null = 1'b0;
  logic use_or = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [cian_pkg::FieldW-1:0] result_value;
  logic result_is_null;
  logic [1:0] status;

  alu_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  longint unsigned cycle_count = 0;
  bit hold_off = 1'b0;
  bit stall_random = 1'b1;

  checked_int_alu_with_nulls_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .operand_a(operand_a), .operand_b(operand_b),
    .a_is_null(a_is_null), .b_is_null(b_is_null), .use_or(use_or),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .result_is_null(result_is_null), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Signed arithmetic with SQL NULL rules; 64-bit data so no narrowing needed.
  function automatic alu_result_t eval_alu(logic [3:0] k, logic [63:0] a, logic [63:0] b,
                                           logic an, logic bn, logic orr);
    alu_result_t r;
    logic signed [63:0] sa, sb;
    logic signed [127:0] wide;
    logic [63:0] q, ma, mb;
    bit at, af, bt, bf;
    r = '0;
    sa = a;
    sb = b;
    if (k == cian_pkg::KIND_LOGIC) begin
      at = !an && a != 0; af = !an && a == 0;
      bt = !bn && b != 0; bf = !bn && b == 0;
      if (!orr) begin
        if (af || bf) r.value = 0;
        else if (an || bn) r.is_null = 1;
        else r.value = 1;
      end else begin
        if (at || bt) r.value = 1;
        else if (an || bn) r.is_null = 1;
        else r.value = 0;
      end
    end else if (k == cian_pkg::KIND_NEG || k == cian_pkg::KIND_NOT) begin
      if (an) r.is_null = 1;
      else if (k == cian_pkg::KIND_NOT) r.value = (a == 0);
      else if (a == MinVal) r.st = cian_pkg::ST_OVF;
      else r.value = -a;
    end else if (k <= cian_pkg::KIND_GE) begin
      if (an || bn) r.is_null = 1;
      else case (k)
        cian_pkg::KIND_EQ: r.value = (sa == sb);
        cian_pkg::KIND_NE: r.value = (sa != sb);
        cian_pkg::KIND_LT: r.value = (sa < sb);
        cian_pkg::KIND_LE: r.value = (sa <= sb);
        cian_pkg::KIND_GT: r.value = (sa > sb);
        cian_pkg::KIND_GE: r.value = (sa >= sb);
        cian_pkg::KIND_DIV: begin
          if (b == 0) r.st = cian_pkg::ST_DIV0;
          else if (a == MinVal && b == MinusOne) r.st = cian_pkg::ST_OVF;
          else begin
            ma = sa[63] ? -a : a;
            mb = sb[63] ? -b : b;
            q = ma / mb;
            r.value = (sa[63] ^ sb[63]) ? -q : q;
          end
        end
        default: begin
          if (k == cian_pkg::KIND_ADD) wide = 128'(sa) + 128'(sb);
          else if (k == cian_pkg::KIND_SUB) wide = 128'(sa) - 128'(sb);
          else wide = 128'(sa) * 128'(sb);
          if (wide > 128'sh7FFF_FFFF_FFFF_FFFF || wide < -128'sh8000_0000_0000_0000)
            r.st = cian_pkg::ST_OVF;
          else r.value = wide[63:0];
        end
      endcase
    end
    return r;
  endfunction

  // Receiver: random stall pattern, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_random) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_value !== exp_r.value) begin
          $error("result_value exp %h got %h", exp_r.value, result_value); errors++;
        end
        if (result_is_null !== exp_r.is_null) begin
          $error("result_is_null exp %b got %b", exp_r.is_null, result_is_null); errors++;
        end
        if (status !== exp_r.st) begin
          $error("status exp %0d got %0d", exp_r.st, status); errors++;
        end
      end
    end
  end

  task automatic send_word(logic [3:0] k, logic [63:0] a, logic [63:0] b,
                           logic an, logic bn, logic orr);
    in_valid <= 1'b1;
    kind <= k; operand_a <= a; operand_b <= b;
    a_is_null <= an; b_is_null <= bn; use_or <= orr;
    expected_results.insert(expected_results.size(), eval_alu(k, a, b, an, bn, orr));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MinVal;
      1: return MaxVal;
      2: return MinusOne;
      3: return 64'($urandom_range(0, 3));
      4: return {32'($signed(-1)), $urandom()};
      5: return 64'($urandom_range(0, 1000));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic test_directed();
    logic [63:0] edges[6];
    edges = '{MinVal, MaxVal, MinusOne, 64'd0, 64'd1, 64'h5555_AAAA_5555_AAAA};
    for (int k = 0; k <= 15; k++)
      send_word(4'(k), edges[k % 6], edges[(k + 1) % 6], 1'b0, 1'b0, k[0]);
    send_word(cian_pkg::KIND_DIV, 64'd7, 64'd0, 1'b1, 1'b0, 1'b0);  // null beats div by zero
    send_word(cian_pkg::KIND_DIV, MinVal, MinusOne, 1'b0, 1'b0, 1'b0);
    send_word(cian_pkg::KIND_DIV, 64'd5, 64'd0, 1'b0, 1'b0, 1'b0);
    send_word(cian_pkg::KIND_NEG, MinVal, 64'd0, 1'b0, 1'b1, 1'b0);
    send_word(cian_pkg::KIND_MUL, MinVal, 64'd1, 1'b0, 1'b0, 1'b0);
    send_word(cian_pkg::KIND_MUL, MaxVal, MaxVal, 1'b0, 1'b0, 1'b0);
    send_word(cian_pkg::KIND_LOGIC, 64'd0, 64'd9, 1'b0, 1'b1, 1'b0);
    send_word(cian_pkg::KIND_LOGIC, 64'd3, 64'd0, 1'b0, 1'b1, 1'b1);
    send_word(cian_pkg::KIND_ADD, MaxVal, 64'd1, 1'b0, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_random(int count);
    int burst;
    for (int i = 0; i < count; i++) begin
      send_word(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                ($urandom_range(0, 5) == 0), ($urandom_range(0, 5) == 0),
                1'($urandom_range(0, 1)));
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 1)) begin
          go_idle();
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end else burst--;
    end
    drain();
  endtask

  // Receiver blocks long enough that the pipe fills and stalls the input.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3 * Latency) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 150; i++)
        send_word(cian_pkg::KIND_DIV, pick_operand(), pick_operand(), 1'b0, 1'b0, 1'b0);
    join
    drain();
  endtask

  task automatic test_full_rate();
    stall_random = 1'b0;
    for (int i = 0; i < 200; i++)
      send_word(4'($urandom_range(0, 12)), pick_operand(), pick_operand(),
                1'b0, 1'b0, 1'($urandom_range(0, 1)));
    drain();
    stall_random = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1000);
    test_backpressure();
    test_full_rate();
    test_random(700);
    repeat (Latency + 10) @(posedge clk);
    $display("Covered all kinds, null and error cases, random bursts, backpressure;");
    $display("%0d result words checked.", results_seen);
    if (errors == 0 && expected_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
